// File: rtl/core/swrms_pkg.sv
// Shared types and constants for the sliding window RMS level unit.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package swrms_pkg;

  // Window register width and reset value
  localparam int unsigned CFG_W        = 9;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 9'd64;
  localparam int unsigned WIN_MIN      = 2;

  // 0.6667 in Q0.16
  localparam int unsigned GAIN_W       = 16;
  localparam logic [GAIN_W-1:0] LEVEL_GAIN = 16'd43692;

  // Controller to datapath commands, one strobe per step
  typedef struct packed {
    logic accept;     // latch sample magnitude, ring read issued
    logic square;     // square sample, capture retiring ring entry
    logic load;       // form dividend = sum + square
    logic update;     // retire oldest square, write ring, advance position
    logic div_step;   // one quotient bit
    logic root_init;  // load radicand into root unit
    logic root_step;  // one root bit
    logic scale;      // multiply root by gain
    logic emit;       // load output register
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/swrms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module swrms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 255
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/core/swrms_ctrl.sv
// Sequencing state machine for the RMS level unit: handshakes and step commands.
// Depends on swrms_pkg.
`default_nettype none

module swrms_ctrl #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output swrms_pkg::cmd_t      cmd
);
  import swrms_pkg::*;

  localparam int unsigned DIV_STEPS  = 2 * SAMPLE_BITS - 1;
  localparam int unsigned ROOT_STEPS = SAMPLE_BITS;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_LOAD,
    ST_UPDATE,
    ST_DIV,
    ST_RINIT,
    ST_ROOT,
    ST_SCALE,
    ST_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_tready;

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.accept    = (state_r == ST_IDLE) && in_tvalid;
    cmd.square    = (state_r == ST_SQUARE);
    cmd.load      = (state_r == ST_LOAD);
    cmd.update    = (state_r == ST_UPDATE);
    cmd.div_step  = (state_r == ST_DIV);
    cmd.root_init = (state_r == ST_RINIT);
    cmd.root_step = (state_r == ST_ROOT);
    cmd.scale     = (state_r == ST_SCALE);
    cmd.emit      = (state_r == ST_EMIT) && out_free;
  end

  // next state, step counter and output valid
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        state_nxt = ST_DIV;
        count_nxt = '0;
      end
      ST_DIV: begin
        count_nxt = count_r + CNT_W'(1);
        if (count_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_RINIT;
        end
      end
      ST_RINIT: begin
        state_nxt = ST_ROOT;
        count_nxt = '0;
      end
      ST_ROOT: begin
        count_nxt = count_r + CNT_W'(1);
        if (count_r == CNT_W'(ROOT_STEPS - 1)) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

`ifndef ASSERT_OFF
  // only one transaction in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in progress");

  // output register is loaded only from the emit step
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.emit))
    else $error("output valid rose without an emit command");
`endif

endmodule

`default_nettype wire

// File: rtl/core/swrms_dp.sv
// Datapath for the RMS level unit: window register, square ring and running sum,
// bit-serial divider, bit-serial square root, gain multiply and output register.
// Depends on swrms_pkg and swrms_ram.
`default_nettype none

module swrms_dp #(
  parameter int unsigned MAX_WINDOW  = 256,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire swrms_pkg::cmd_t              cmd,
  input  wire logic                         cfg_wen,
  input  wire logic [swrms_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire logic [SAMPLE_BITS-1:0]       sample,
  output logic      [SAMPLE_BITS-1:0]       level
);
  import swrms_pkg::*;

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned SQ_W   = 2 * SB;
  localparam int unsigned SUM_W  = SQ_W + $clog2(MAX_WINDOW);
  localparam int unsigned QW     = 2 * SB - 1;
  localparam int unsigned WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned DEPTH  = MAX_WINDOW - 1;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PROD_W = SB + GAIN_W;

  logic [CFG_W-1:0]  window_r;
  logic [WIN_W-1:0]  win_eff;
  logic [SB-1:0]     mag_r;
  logic [SQ_W-1:0]   sq_r;
  logic [SQ_W-1:0]   old_r;
  logic [SQ_W-1:0]   ring_rdata;
  logic [SUM_W-1:0]  dnum_r;
  logic [SUM_W-1:0]  sum_r;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic              wrapped_r;
  logic              pos_at_end;
  logic [WIN_W-1:0]  rem_r;
  logic [QW-1:0]     quo_r;
  logic [WIN_W:0]    div_t;
  logic              div_ge;
  logic [SQ_W-1:0]   rad_r;
  logic [SB-1:0]     root_r;
  logic [SB:0]       srem_r;
  logic [SB+2:0]     sr_t;
  logic [SB+2:0]     sr_trial;
  logic              sr_ge;
  logic [PROD_W-1:0] prod_r;
  logic [SB-1:0]     level_r;

  // clamp the window register to the supported range
  always_comb begin
    if (32'(window_r) < 32'(WIN_MIN)) begin
      win_eff = WIN_W'(WIN_MIN);
    end else if (32'(window_r) > 32'(MAX_WINDOW)) begin
      win_eff = WIN_W'(MAX_WINDOW);
    end else begin
      win_eff = WIN_W'(window_r);
    end
  end

  // ring position advance with wrap after window-2
  assign pos_at_end = (WIN_W'(pos_r) == (win_eff - WIN_W'(2)));
  assign pos_nxt    = pos_at_end ? '0 : (pos_r + AW'(1));

  // history state: window, sum, position, wrap flag (config write clears)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= WINDOW_RESET;
      sum_r     <= '0;
      pos_r     <= '0;
      wrapped_r <= 1'b0;
    end else if (cfg_wen) begin
      window_r  <= cfg_wdata;
      sum_r     <= '0;
      pos_r     <= '0;
      wrapped_r <= 1'b0;
    end else if (cmd.update) begin
      sum_r <= dnum_r - SUM_W'(old_r);
      pos_r <= pos_nxt;
      if (pos_at_end) begin
        wrapped_r <= 1'b1;
      end
    end
  end

  // square ring; an entry at the current position is valid only once wrapped
  swrms_ram #(
    .WIDTH (SQ_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update && !cfg_wen),
    .waddr (pos_r),
    .wdata (sq_r),
    .raddr (pos_r),
    .rdata (ring_rdata)
  );

  // sample magnitude, square, retiring entry, dividend
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mag_r <= sample[SB-1] ? (~sample + SB'(1)) : sample;
    end
    if (cmd.square) begin
      sq_r  <= SQ_W'(mag_r) * SQ_W'(mag_r);
      old_r <= wrapped_r ? ring_rdata : '0;
    end
    if (cmd.load) begin
      dnum_r <= sum_r + SUM_W'(sq_r);
    end
  end

  // restoring divider, one quotient bit per cycle; quotient fits in QW bits
  assign div_t  = {rem_r, quo_r[QW-1]};
  assign div_ge = (div_t >= {1'b0, win_eff});

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      rem_r <= WIN_W'(dnum_r >> QW);
      quo_r <= dnum_r[QW-1:0];
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? WIN_W'(div_t - {1'b0, win_eff}) : WIN_W'(div_t);
      quo_r <= {quo_r[QW-2:0], div_ge};
    end
  end

  // digit-by-digit square root, one root bit per cycle
  assign sr_t     = {srem_r, rad_r[SQ_W-1 -: 2]};
  assign sr_trial = {1'b0, root_r, 2'b01};
  assign sr_ge    = (sr_t >= sr_trial);

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rad_r  <= {1'b0, quo_r};
      root_r <= '0;
      srem_r <= '0;
    end else if (cmd.root_step) begin
      rad_r  <= rad_r << 2;
      root_r <= {root_r[SB-2:0], sr_ge};
      srem_r <= sr_ge ? (SB+1)'(sr_t - sr_trial) : (SB+1)'(sr_t);
    end
  end

  // gain multiply and level offset by -1.0
  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      prod_r <= PROD_W'(root_r) * PROD_W'(LEVEL_GAIN);
    end
    if (cmd.emit) begin
      level_r <= prod_r[PROD_W-1:GAIN_W] - {1'b1, {(SB-1){1'b0}}};
    end
  end

  assign level = level_r;

`ifndef ASSERT_OFF
  // ring position always stays inside the active window
  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    WIN_W'(pos_r) <= (win_eff - WIN_W'(2)))
    else $error("ring position outside window");

  // window write restarts the history
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wen |=> (pos_r == '0) && !wrapped_r && (sum_r == '0))
    else $error("history not cleared after window write");
`endif

endmodule

`default_nettype wire

// File: rtl/core/sliding_window_rms_level_unit.sv
// Each input runs the square, load and update steps, then the bit-serial divider
//   (2*SAMPLE_BITS-1 steps) and square root (SAMPLE_BITS steps) in sequence, then
//   scale and emit; a new sample is taken only once the previous one is finished.
// A finished level waits in the output register while the next sample is taken.
// Reset (rst_n low, synchronous): window 64, running sum, ring position cleared;
//   ring contents are masked by a wrap flag, so no clearing pass is needed.
`default_nettype none

module sliding_window_rms_level_unit #(
  parameter int unsigned MAX_WINDOW  = 256,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // in_tdata: [SAMPLE_BITS-1:0] sample, rest zero
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  // out_tdata: [SAMPLE_BITS-1:0] level, rest zero
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic      [((SAMPLE_BITS+7)/8)*8-1:0]     out_tdata,
  // window_length register
  input  wire logic                                 cfg_wen,
  input  wire logic [swrms_pkg::CFG_W-1:0]          cfg_wdata
);
  import swrms_pkg::*;

  localparam int unsigned TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  cmd_t                   cmd;
  logic [SAMPLE_BITS-1:0] level;

  swrms_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  swrms_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .sample    (in_tdata[SAMPLE_BITS-1:0]),
    .level     (level)
  );

  // zero-pad the level to whole bytes
  assign out_tdata = TDATA_W'(level);

endmodule

`default_nettype wire
